@@ rtl/eflba_pkg.sv @@
// Shared types and constants for the extent free-list block allocator.
// Depends on nothing; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package eflba_pkg;

  localparam int NUM_BLOCKS = 1024;
  localparam int BLK_W      = 10;
  localparam int ADDR_W     = $clog2(NUM_BLOCKS);
  localparam int HDR_W      = 2 * BLK_W;
  localparam int STATUS_W   = 2;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 24;

  localparam logic [BLK_W-1:0] USABLE_RESET = BLK_W'(1023);
  localparam logic [BLK_W-1:0] MAX_USABLE   = BLK_W'(NUM_BLOCKS - 1);
  localparam logic [BLK_W:0]   NUM_BLOCKS_EXT = (BLK_W + 1)'(NUM_BLOCKS);

  typedef enum logic [1:0] {
    MODE_FORMAT = 2'd0,
    MODE_ALLOC  = 2'd1,
    MODE_FREE   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_REJECTED = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;          // input word accepted this cycle
    logic alloc_finish;  // head header is in the read register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic  out_busy;     // output register holds a word that is not taken
    logic  alloc_empty;  // free list is empty
    mode_t mode;         // mode of the word on the input
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/eflba_ctrl.sv @@
// Controller state machine for the extent free-list block allocator.
// Depends on eflba_pkg; drives the datapath through cmd_t, watches sts_t.
`timescale 1ns / 1ps
`default_nettype none

module eflba_ctrl
  import eflba_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic s_tvalid,
  output logic       s_tready,
  input  wire  sts_t sts,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && !sts.out_busy && sts.mode == MODE_ALLOC && !sts.alloc_empty) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The output register is free in the read state: a word is accepted only
  // when the register is empty or being emptied at that same edge.
  // Nothing is accepted while reset is held.
  always_comb begin
    s_tready         = 1'b0;
    cmd.take         = 1'b0;
    cmd.alloc_finish = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = !sts.out_busy && !rst;
        cmd.take = s_tvalid && !sts.out_busy && !rst;
      end
      S_READ: begin
        cmd.alloc_finish = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/eflba_datapath.sv @@
// Datapath: header memory, free-list registers, usable_blocks register and the
// output register. Depends on eflba_pkg; commanded by eflba_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module eflba_datapath
  import eflba_pkg::*;
(
  input  wire  logic             clk,
  input  wire  logic             rst,
  input  wire  logic             cfg_we,
  input  wire  logic [BLK_W-1:0] cfg_wdata,
  input  wire  logic [IN_W-1:0]  s_tdata,
  input  wire  cmd_t             cmd,
  output sts_t                   sts,
  output logic                   m_tvalid,
  input  wire  logic             m_tready,
  output logic [OUT_W-1:0]       m_tdata
);

  logic [HDR_W-1:0]  headers [NUM_BLOCKS];
  logic [HDR_W-1:0]  rd_data;
  logic              rd_oob;

  logic [BLK_W-1:0]  usable_blocks;
  logic [BLK_W-1:0]  first_free;
  logic [BLK_W-1:0]  first_free_next;
  logic [BLK_W-1:0]  free_blocks;
  logic [BLK_W-1:0]  free_blocks_next;

  logic [BLK_W-1:0]  out_block;
  logic [BLK_W-1:0]  out_block_next;
  status_t           out_status;
  status_t           out_status_next;
  logic [BLK_W-1:0]  out_count_next;
  logic              load_out;

  logic              wr_en;
  logic [BLK_W-1:0]  wr_addr;
  logic [HDR_W-1:0]  wr_data;

  mode_t             mode;
  logic [BLK_W-1:0]  blk;
  logic [BLK_W-1:0]  fmt_len;
  logic              free_bad;
  logic [HDR_W-1:0]  head_hdr;
  logic [BLK_W-1:0]  head_len;
  logic [BLK_W-1:0]  head_next;
  logic [BLK_W-1:0]  head_step;
  logic [BLK_W-1:0]  out_count;

  assign mode = mode_t'(s_tdata[1:0]);
  assign blk  = s_tdata[BLK_W+1:2];

  assign sts.out_busy    = m_tvalid && !m_tready;
  assign sts.alloc_empty = (free_blocks == '0) || (first_free == '0);
  assign sts.mode        = mode;

  assign fmt_len  = (usable_blocks > MAX_USABLE) ? MAX_USABLE : usable_blocks;
  assign free_bad = (blk == '0) || (blk > usable_blocks)
                    || ({1'b0, blk} >= NUM_BLOCKS_EXT)
                    || (free_blocks >= usable_blocks);

  // A header beyond the header memory reads as zero.
  assign head_hdr  = rd_oob ? '0 : rd_data;
  assign head_len  = head_hdr[BLK_W-1:0];
  assign head_next = head_hdr[HDR_W-1:BLK_W];
  assign head_step = first_free + BLK_W'(1);

  always_comb begin
    first_free_next  = first_free;
    free_blocks_next = free_blocks;
    out_block_next   = '0;
    out_status_next  = ST_OK;
    load_out         = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = '0;
    wr_data          = '0;
    if (cmd.alloc_finish) begin
      load_out         = 1'b1;
      out_block_next   = first_free;
      free_blocks_next = free_blocks - BLK_W'(1);
      if (head_len > BLK_W'(1)) begin
        first_free_next = head_step;
        wr_en           = 1'b1;
        wr_addr         = head_step;
        wr_data         = {head_next, head_len - BLK_W'(1)};
      end else begin
        first_free_next = head_next;
      end
    end else if (cmd.take) begin
      unique case (mode)
        MODE_FORMAT: begin
          load_out         = 1'b1;
          first_free_next  = BLK_W'(1);
          free_blocks_next = fmt_len;
          wr_en            = 1'b1;
          wr_addr          = BLK_W'(1);
          wr_data          = {{BLK_W{1'b0}}, fmt_len};
        end
        MODE_ALLOC: begin
          // A non-empty list finishes in the read state.
          if (sts.alloc_empty) begin
            load_out        = 1'b1;
            out_status_next = ST_NO_FREE;
          end
        end
        MODE_FREE: begin
          load_out = 1'b1;
          if (free_bad) begin
            out_status_next = ST_REJECTED;
          end else begin
            first_free_next  = blk;
            free_blocks_next = free_blocks + BLK_W'(1);
            wr_en            = 1'b1;
            wr_addr          = blk;
            wr_data          = {first_free, BLK_W'(1)};
          end
        end
        MODE_NONE: begin
          load_out = 1'b1;
        end
        default: begin
        end
      endcase
    end
    out_count_next = free_blocks_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en && ({1'b0, wr_addr} < NUM_BLOCKS_EXT)) begin
      headers[ADDR_W'(wr_addr)] <= wr_data;
    end
    rd_data <= headers[ADDR_W'(first_free)];
    rd_oob  <= ({1'b0, first_free} >= NUM_BLOCKS_EXT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      usable_blocks <= USABLE_RESET;
      first_free    <= '0;
      free_blocks   <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        usable_blocks <= cfg_wdata;
      end
      first_free  <= first_free_next;
      free_blocks <= free_blocks_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_block  <= out_block_next;
      out_status <= out_status_next;
      out_count  <= out_count_next;
    end
  end

  assign m_tdata = {{(OUT_W - 2 * BLK_W - STATUS_W){1'b0}}, out_count, out_status, out_block};

endmodule

`default_nettype wire

@@ rtl/extent_free_list_block_allocator.sv @@
// Top level of the extent free-list block allocator.
// Depends on eflba_pkg, eflba_ctrl and eflba_datapath.
// Format, free and an empty-list allocate load their result word on acceptance;
// a non-empty allocate first passes the read state, for the registered read of
// the head header before its rewrite; no word is accepted in the read state.
// Throughput: one word per cycle while the output is taken, save in the read state.
// Reset (rst, synchronous): empty free list, zero free count, usable_blocks
// 1023; header memory contents are undefined until formatted.
`timescale 1ns / 1ps
`default_nettype none

module extent_free_list_block_allocator
  import eflba_pkg::*;
(
  input  wire  logic             clk,
  input  wire  logic             rst,
  input  wire  logic             cfg_we,
  input  wire  logic [BLK_W-1:0] cfg_wdata,  // usable_blocks
  input  wire  logic             s_tvalid,
  output logic                   s_tready,
  input  wire  logic [IN_W-1:0]  s_tdata,    // mode[1:0], block_index[11:2], zero fill
  output logic                   m_tvalid,
  input  wire  logic             m_tready,
  output logic [OUT_W-1:0]       m_tdata     // allocated_block[9:0], status[11:10],
                                             // free_count[21:12], zero fill
);

  cmd_t cmd;
  sts_t sts;

  eflba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  eflba_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire
